### hw/rtl/dtc_pkg.sv
package dtc_pkg;

  // tree and feature capacity
  localparam int MAX_NODES   = 256;
  localparam int MAX_LEAVES  = 256;
  localparam int FEATURE_DIM = 64;
  localparam int NUM_CLASSES = 16;
  localparam int DEPTH_LIMIT = 16;

  localparam int NodeAw  = $clog2(MAX_NODES);
  localparam int LeafAw  = $clog2(MAX_LEAVES);
  localparam int FeatAw  = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
  localparam int DepthW  = $clog2(DEPTH_LIMIT + 1);

  // fixed field widths
  localparam int CmdW  = 2;
  localparam int IdxW  = 8;
  localparam int FselW = 6;
  localparam int RefW  = 9;
  localparam int ValW  = 16;
  localparam int ClsW  = $clog2(NUM_CLASSES);
  localparam int StatW = 2;

  // request queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [CmdW-1:0] {
    CMD_NODE     = 2'd0,
    CMD_LEAF     = 2'd1,
    CMD_FEAT     = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_e;

  localparam logic [StatW-1:0] ST_WRITE_OK  = 2'd0;
  localparam logic [StatW-1:0] ST_DONE      = 2'd1;
  localparam logic [StatW-1:0] ST_DEPTH_ERR = 2'd2;

  typedef struct packed {
    cmd_e                   op;
    logic [IdxW-1:0]        idx;
    logic [FselW-1:0]       fsel;
    logic signed [ValW-1:0] thr;
    logic signed [RefW-1:0] lref;
    logic signed [RefW-1:0] rref;
    logic [ClsW-1:0]        cls;
    logic signed [ValW-1:0] fval;
  } req_t;

  typedef struct packed {
    logic [FselW-1:0]       fsel;
    logic signed [ValW-1:0] thr;
    logic signed [RefW-1:0] lref;
    logic signed [RefW-1:0] rref;
  } node_t;

endpackage

### hw/rtl/dtc_front.sv
module dtc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dtc_pkg::CmdW-1:0]       cmd_i,
  input  logic [dtc_pkg::IdxW-1:0]       entry_index_i,
  input  logic [dtc_pkg::FselW-1:0]      feature_select_i,
  input  logic signed [dtc_pkg::ValW-1:0] split_threshold_i,
  input  logic signed [dtc_pkg::RefW-1:0] left_ref_i,
  input  logic signed [dtc_pkg::RefW-1:0] right_ref_i,
  input  logic [dtc_pkg::ClsW-1:0]       class_value_i,
  input  logic signed [dtc_pkg::ValW-1:0] feature_value_i,
  output logic                           q_valid_o,
  output dtc_pkg::req_t                  q_req_o,
  input  logic                           q_pop_i
);

  dtc_pkg::req_t               q_mem [dtc_pkg::QDepth];
  logic [dtc_pkg::QAw-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dtc_pkg::QAw-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dtc_pkg::QAw:0]       cnt_q, cnt_d;
  logic                        push;
  logic                        pop;
  dtc_pkg::req_t               req_in;

  always_comb begin
    req_in.op   = dtc_pkg::cmd_e'(cmd_i);
    req_in.idx  = entry_index_i;
    req_in.fsel = feature_select_i;
    req_in.thr  = split_threshold_i;
    req_in.lref = left_ref_i;
    req_in.rref = right_ref_i;
    req_in.cls  = class_value_i;
    req_in.fval = feature_value_i;
  end

  assign in_stall_o = (cnt_q == (dtc_pkg::QAw+1)'(dtc_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= req_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (dtc_pkg::QAw+1)'(dtc_pkg::QDepth))
    else $error("request queue overfilled");

endmodule

### hw/rtl/dtc_back.sv
module dtc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic signed [dtc_pkg::RefW-1:0]  cfg_wdata_i,
  input  logic                             q_valid_i,
  input  dtc_pkg::req_t                    q_req_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dtc_pkg::StatW-1:0]        status_o,
  output logic [dtc_pkg::ClsW-1:0]         predicted_class_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NODE = 2'd1;  // node data arriving
  localparam logic [1:0] S_FEAT = 2'd2;  // feature data arriving
  localparam logic [1:0] S_LEAF = 2'd3;  // leaf label arriving

  logic [1:0]                    state_q, state_d;
  logic [dtc_pkg::DepthW-1:0]    depth_q, depth_d;
  logic signed [dtc_pkg::RefW-1:0] root_q;

  dtc_pkg::node_t                node_mem [dtc_pkg::MAX_NODES];
  logic [dtc_pkg::ClsW-1:0]      leaf_mem [dtc_pkg::MAX_LEAVES];
  logic signed [dtc_pkg::ValW-1:0] feat_mem [dtc_pkg::FEATURE_DIM];

  logic                          node_we, leaf_we, feat_we;
  logic                          node_re, leaf_re, feat_re;
  logic [dtc_pkg::NodeAw-1:0]    node_raddr;
  logic [dtc_pkg::LeafAw-1:0]    leaf_raddr;
  logic [dtc_pkg::FeatAw-1:0]    feat_raddr;
  logic                          node_oob, leaf_oob, feat_oob;
  dtc_pkg::node_t                node_q;
  logic                          node_oob_q;
  logic [dtc_pkg::ClsW-1:0]      leaf_q;
  logic                          leaf_oob_q;
  logic signed [dtc_pkg::ValW-1:0] feat_q;
  logic                          feat_oob_q;

  dtc_pkg::node_t                node_eff;
  logic signed [dtc_pkg::ValW-1:0] fv_eff;
  logic signed [dtc_pkg::RefW-1:0] walk_ref;
  logic [dtc_pkg::RefW-1:0]      leaf_ref;
  logic                          walk_go;
  logic                          out_free;

  logic                          out_load;
  logic [dtc_pkg::StatW-1:0]     res_status;
  logic [dtc_pkg::ClsW-1:0]      res_cls;
  logic                          out_vld_q;
  logic [dtc_pkg::StatW-1:0]     status_q;
  logic [dtc_pkg::ClsW-1:0]      cls_q;

  // a node beyond capacity reads as all zero fields
  assign node_eff = node_oob_q ? '0 : node_q;
  assign fv_eff   = feat_oob_q ? '0 : feat_q;
  assign out_free = !out_vld_q || !out_stall_i;

  // negative ref r names leaf -r-1, which is ~r
  assign leaf_ref   = ~walk_ref;
  assign node_raddr = dtc_pkg::NodeAw'($unsigned(walk_ref));
  assign leaf_raddr = dtc_pkg::LeafAw'(leaf_ref);
  assign node_oob   = (32'($unsigned(walk_ref)) >= 32'(dtc_pkg::MAX_NODES));
  assign leaf_oob   = (32'(leaf_ref) >= 32'(dtc_pkg::MAX_LEAVES));
  assign feat_raddr = dtc_pkg::FeatAw'(node_eff.fsel);
  assign feat_oob   = (32'(node_eff.fsel) >= 32'(dtc_pkg::FEATURE_DIM));

  assign node_we = q_pop_o && (q_req_i.op == dtc_pkg::CMD_NODE)
                   && (32'(q_req_i.idx) < 32'(dtc_pkg::MAX_NODES));
  assign leaf_we = q_pop_o && (q_req_i.op == dtc_pkg::CMD_LEAF)
                   && (32'(q_req_i.idx) < 32'(dtc_pkg::MAX_LEAVES));
  assign feat_we = q_pop_o && (q_req_i.op == dtc_pkg::CMD_FEAT)
                   && (32'(q_req_i.idx) < 32'(dtc_pkg::FEATURE_DIM));

  always_comb begin
    state_d    = state_q;
    depth_d    = depth_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    res_status = dtc_pkg::ST_WRITE_OK;
    res_cls    = '0;
    walk_ref   = root_q;
    walk_go    = 1'b0;
    feat_re    = 1'b0;
    node_re    = 1'b0;
    leaf_re    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_req_i.op == dtc_pkg::CMD_CLASSIFY) begin
            walk_go = 1'b1;
            depth_d = '0;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      S_NODE: begin
        feat_re = 1'b1;
        state_d = S_FEAT;
      end
      S_FEAT: begin
        walk_ref = (fv_eff > node_eff.thr) ? node_eff.rref : node_eff.lref;
        if (!walk_ref[dtc_pkg::RefW-1]
            && (depth_q == dtc_pkg::DepthW'(dtc_pkg::DEPTH_LIMIT - 1))) begin
          out_load   = 1'b1;
          res_status = dtc_pkg::ST_DEPTH_ERR;
          state_d    = S_IDLE;
        end else begin
          walk_go = 1'b1;
          depth_d = depth_q + 1'b1;
        end
      end
      S_LEAF: begin
        out_load   = 1'b1;
        res_status = dtc_pkg::ST_DONE;
        res_cls    = leaf_oob_q ? '0 : leaf_q;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (walk_go) begin
      if (walk_ref[dtc_pkg::RefW-1]) begin
        leaf_re = 1'b1;
        state_d = S_LEAF;
      end else begin
        node_re = 1'b1;
        state_d = S_NODE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= '0;
      root_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= res_status;
      cls_q    <= res_cls;
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[dtc_pkg::NodeAw'(q_req_i.idx)] <=
        '{fsel: q_req_i.fsel, thr: q_req_i.thr, lref: q_req_i.lref, rref: q_req_i.rref};
    end
    if (node_re) begin
      node_q     <= node_mem[node_raddr];
      node_oob_q <= node_oob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[dtc_pkg::LeafAw'(q_req_i.idx)] <= q_req_i.cls;
    end
    if (leaf_re) begin
      leaf_q     <= leaf_mem[leaf_raddr];
      leaf_oob_q <= leaf_oob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[dtc_pkg::FeatAw'(q_req_i.idx)] <= q_req_i.fval;
    end
    if (feat_re) begin
      feat_q     <= feat_mem[feat_raddr];
      feat_oob_q <= feat_oob;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = status_q;
  assign predicted_class_o = cls_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE))
    else $error("request taken in the middle of a walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_vld_q)
    else $error("walk running while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_NODE) || (state_q == S_FEAT))
      |-> (depth_q <= dtc_pkg::DepthW'(dtc_pkg::DEPTH_LIMIT - 1)))
    else $error("walk depth past limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status == dtc_pkg::ST_DEPTH_ERR)) |-> (state_q == S_FEAT))
    else $error("depth error outside a node test");

endmodule

### hw/rtl/decision_tree_classify_core.sv
// Decision tree classifier. Requests write split nodes, leaf labels and
// feature samples into on-chip memories, or classify the stored feature
// vector by walking from the root reference; every request returns one
// result. A four-deep request queue sits between the input side and the
// executing back end, and the result sits in its own register, so input is
// taken while a result waits. The back end takes a request only while idle
// with its result register free. Each node visit of a classify is a
// node-memory read followed by a dependent feature-memory read, and the final
// leaf label is one more read. The user must write root_ref through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block does not enforce this.
module decision_tree_classify_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic signed [dtc_pkg::RefW-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dtc_pkg::CmdW-1:0]         cmd_i,
  input  logic [dtc_pkg::IdxW-1:0]         entry_index_i,
  input  logic [dtc_pkg::FselW-1:0]        feature_select_i,
  input  logic signed [dtc_pkg::ValW-1:0]  split_threshold_i,
  input  logic signed [dtc_pkg::RefW-1:0]  left_ref_i,
  input  logic signed [dtc_pkg::RefW-1:0]  right_ref_i,
  input  logic [dtc_pkg::ClsW-1:0]         class_value_i,
  input  logic signed [dtc_pkg::ValW-1:0]  feature_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dtc_pkg::StatW-1:0]        status_o,
  output logic [dtc_pkg::ClsW-1:0]         predicted_class_o
);

  logic          q_valid;
  logic          q_pop;
  dtc_pkg::req_t q_req;

  dtc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .entry_index_i     (entry_index_i),
    .feature_select_i  (feature_select_i),
    .split_threshold_i (split_threshold_i),
    .left_ref_i        (left_ref_i),
    .right_ref_i       (right_ref_i),
    .class_value_i     (class_value_i),
    .feature_value_i   (feature_value_i),
    .q_valid_o         (q_valid),
    .q_req_o           (q_req),
    .q_pop_i           (q_pop)
  );

  dtc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .q_valid_i         (q_valid),
    .q_req_i           (q_req),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .predicted_class_o (predicted_class_o)
  );

endmodule
